### hdl/frti_pkg.sv
// Package for the round-to-integral unit: opcodes, field widths, register index and beat types.
package frti_pkg;

  localparam int unsigned DataW = 64;

  typedef enum logic [1:0] {
    OP_ROUND  = 2'd0,
    OP_TRUNC  = 2'd1,
    OP_LROUND = 2'd2,
    OP_LLROUND = 2'd3
  } op_e;

  // register index on the configuration port
  localparam logic [0:0] RegLongIsWide = 1'b0;

  // beat moving between pipeline stages
  typedef struct packed {
    logic             vld;
    op_e              op;
    logic             sp;
    logic             wide;     // integer width 64 when set
    logic [DataW-1:0] x;        // operand, upper half cleared in binary32 mode
    logic             is_nan;
  } beat_t;

  typedef struct packed {
    logic             vld;
    op_e              op;
    logic             sp;
    logic             wide;
    logic             is_nan;
    logic [DataW-1:0] t;        // integral value in float format
    logic             inx;
  } rbeat_t;

endpackage

### hdl/frti_round.sv
// Stage two: round or truncate the operand to an integral float.
module frti_round (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  frti_pkg::beat_t in_i,
  output frti_pkg::rbeat_t out_o
);
  import frti_pkg::*;

  logic [10:0] bias, mb;
  logic [63:0] sgn, mag, s, one, half, big, mask, rmag, t_d;
  logic [10:0] e, fb;
  logic        chop, inx_d;
  rbeat_t      out_q;

  // integral_of on the bit pattern
  always_comb begin
    mb   = in_i.sp ? 11'd23 : 11'd52;
    bias = in_i.sp ? 11'd127 : 11'd1023;
    sgn  = in_i.sp ? 64'h8000_0000 : 64'h8000_0000_0000_0000;
    mag  = in_i.x & (sgn - 64'd1);
    s    = in_i.x & sgn;
    one  = {53'd0, bias} << mb;
    half = {53'd0, bias - 11'd1} << mb;
    big  = {53'd0, bias + mb} << mb;
    chop = (in_i.op == OP_TRUNC);
    e    = 11'((mag >> mb) - {53'd0, bias});
    fb   = mb - e;
    mask = (64'd1 << fb) - 64'd1;
    rmag = mag;
    inx_d = 1'b0;
    t_d  = in_i.x;
    if (mag >= big) begin
      t_d = in_i.x;
    end else if (mag < one) begin
      inx_d = (mag != 64'd0);
      t_d = (!chop && mag >= half) ? (s | one) : s;
    end else begin
      inx_d = ((mag & mask) != 64'd0);
      if (!chop) rmag = mag + (64'd1 << (fb - 11'd1));
      t_d = s | (rmag & ~mask);
    end
  end

  // stage register; valid bit travels with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else begin
      out_q.vld    <= in_i.vld;
      out_q.op     <= in_i.op;
      out_q.sp     <= in_i.sp;
      out_q.wide   <= in_i.wide;
      out_q.is_nan <= in_i.is_nan;
      out_q.t      <= t_d;
      out_q.inx    <= inx_d;
    end
  end

  assign out_o = out_q;
endmodule

### hdl/frti_convert.sv
// Stage three: turn the integral float into a saturated integer or pass it on.
module frti_convert (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  frti_pkg::rbeat_t in_i,
  output logic             vld_o,
  output logic [63:0]      res_o,
  output logic             inv_o,
  output logic             inx_o
);
  import frti_pkg::*;

  logic [10:0] bias, mb, ef, e, lim;
  logic [63:0] sgn, mag, frac, sig, m, maxv, minv, res_d;
  logic        neg, inv_d, inx_d;
  logic        vld_q, inv_q, inx_q;
  logic [63:0] res_q;

  always_comb begin
    mb   = in_i.sp ? 11'd23 : 11'd52;
    bias = in_i.sp ? 11'd127 : 11'd1023;
    sgn  = in_i.sp ? 64'h8000_0000 : 64'h8000_0000_0000_0000;
    maxv = in_i.wide ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h0000_0000_7FFF_FFFF;
    minv = in_i.wide ? 64'h8000_0000_0000_0000 : 64'hFFFF_FFFF_8000_0000;
    neg  = (in_i.t & sgn) != 64'd0;
    mag  = in_i.t & (sgn - 64'd1);
    ef   = 11'(mag >> mb);
    frac = mag & ((64'd1 << mb) - 64'd1);
    lim  = bias + (in_i.wide ? 11'd63 : 11'd31);
    e    = ef - bias;
    sig  = frac | (64'd1 << mb);
    m    = (e >= mb) ? (sig << (e - mb)) : (sig >> (mb - e));
    res_d = in_i.t;
    inv_d = 1'b0;
    inx_d = in_i.inx;
    if (in_i.op == OP_ROUND || in_i.op == OP_TRUNC) begin
      res_d = in_i.t;
    end else if (in_i.is_nan) begin
      res_d = maxv; inv_d = 1'b1; inx_d = 1'b0;
    end else if (mag == 64'd0) begin
      res_d = 64'd0;
    end else if (ef >= lim) begin
      if (neg && ef == lim && frac == 64'd0) begin
        res_d = minv;
      end else begin
        res_d = neg ? minv : maxv; inv_d = 1'b1; inx_d = 1'b0;
      end
    end else begin
      res_d = neg ? (64'd0 - m) : m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= in_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    inv_q <= inv_d;
    inx_q <= inx_d;
  end

  assign vld_o = vld_q;
  assign res_o = res_q;
  assign inv_o = inv_q;
  assign inx_o = inx_q;
endmodule

### hdl/fp_round_to_integral_unit.sv
// Top level of the floating-point round-to-integral and round-to-integer unit.
// Usage:
//   Raise start with opcode_i, single_precision_i and operand_bits_i; the
//   beat is taken on any edge where start is high, busy is always low.
//   A result appears on result_bits_o, invalid_flag_o and inexact_flag_o after the
//   capture, round and convert registers, marked by done_o for exactly one cycle.
//   Throughput is one beat per cycle; three register stages: capture, round, convert.
//   The receiver cannot stall; every result must be taken when done_o is high.
//   long_is_wide (APB address 0) picks 64- or 32-bit width for round-to-long;
//   write it only while the pipeline is empty. Reset sets it to 1 and empties
//   the pipeline.
module fp_round_to_integral_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic        single_precision_i,
  input  logic [63:0] operand_bits_i,
  output logic        done_o,
  output logic [63:0] result_bits_o,
  output logic        invalid_flag_o,
  output logic        inexact_flag_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import frti_pkg::*;

  logic   wide_q;
  beat_t  s1_q;
  rbeat_t s2;
  logic   op_int;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegLongIsWide) ? {31'd0, wide_q} : 32'd0;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == RegLongIsWide) begin
      wide_q <= pwdata[0];
    end
  end

  // capture stage
  assign op_int = opcode_i[1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q.vld  <= start;
      s1_q.op   <= op_e'(opcode_i);
      s1_q.sp   <= single_precision_i;
      s1_q.wide <= (op_e'(opcode_i) == OP_LLROUND) || wide_q;
      if (single_precision_i) begin
        s1_q.x      <= {32'd0, operand_bits_i[31:0]};
        s1_q.is_nan <= op_int && (operand_bits_i[30:0] > 31'h7F80_0000);
      end else begin
        s1_q.x      <= operand_bits_i;
        s1_q.is_nan <= op_int && (operand_bits_i[62:0] > 63'h7FF0_0000_0000_0000);
      end
    end
  end

  frti_round u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (s1_q),
    .out_o  (s2)
  );

  frti_convert u_convert (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (s2),
    .vld_o  (done_o),
    .res_o  (result_bits_o),
    .inv_o  (invalid_flag_o),
    .inx_o  (inexact_flag_o)
  );
endmodule

### sim/tb_top.sv
// Testbench for the round-to-integral unit: directed and random operands against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import frti_pkg::*;

  localparam int unsigned WatchLimit = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode_i = OP_ROUND;
  logic        single_precision_i = 1'b0;
  logic [63:0] operand_bits_i = '0;
  logic        done_o;
  logic [63:0] result_bits_o;
  logic        invalid_flag_o;
  logic        inexact_flag_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  typedef struct packed {
    logic [63:0] bits;
    logic        inv;
    logic        inx;
  } rounded_t;

  rounded_t    rounded_q[$];
  logic        wide_long = 1'b1;
  int unsigned n_err = 0;
  int unsigned n_beats = 0;
  int unsigned n_results = 0;
  int unsigned idle_cycles = 0;
  bit          gaps_on = 1'b1;

  fp_round_to_integral_unit u_dut (.*);

  always #5 clk_i = ~clk_i;

  // integral value in the operand's own format; inexact when any fraction is dropped
  function automatic logic [63:0] to_integral(logic [63:0] x, logic sp, logic chop,
                                              output logic inx);
    int unsigned mb;
    logic [63:0] bias, sgn, mag, s, one, half, big, mask;
    int unsigned fb;
    mb   = sp ? 23 : 52;
    bias = sp ? 64'd127 : 64'd1023;
    sgn  = 64'd1 << (sp ? 31 : 63);
    mag  = x & (sgn - 1);
    s    = x & sgn;
    one  = bias << mb;
    half = (bias - 1) << mb;
    big  = (bias + mb) << mb;
    inx  = 1'b0;
    if (mag >= big) return x;
    if (mag < one) begin
      inx = (mag != 0);
      if (!chop && mag >= half) return s | one;
      return s;
    end
    fb   = mb - int'((mag >> mb) - bias);
    mask = (64'd1 << fb) - 1;
    inx  = ((mag & mask) != 0);
    if (!chop) mag = mag + (64'd1 << (fb - 1));
    return s | (mag & ~mask);
  endfunction

  function automatic rounded_t round_op(op_e op, logic sp, logic [63:0] xin);
    rounded_t r;
    logic [63:0] x, sgn, expall, fmask, t, mag, ef, bias, maxv, minv, sig, m, e;
    int unsigned mb, w;
    logic inx, neg;
    x      = sp ? {32'd0, xin[31:0]} : xin;
    mb     = sp ? 23 : 52;
    bias   = sp ? 64'd127 : 64'd1023;
    sgn    = 64'd1 << (sp ? 31 : 63);
    expall = (sp ? 64'hFF : 64'h7FF) << mb;
    fmask  = (64'd1 << mb) - 1;
    r = '0;
    if (op == OP_ROUND || op == OP_TRUNC) begin
      r.bits = to_integral(x, sp, op == OP_TRUNC, inx);
      r.inx  = inx;
      return r;
    end
    w    = (op == OP_LLROUND || wide_long) ? 64 : 32;
    maxv = (w == 64) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h0000_0000_7FFF_FFFF;
    minv = (w == 64) ? 64'h8000_0000_0000_0000 : 64'hFFFF_FFFF_8000_0000;
    if ((x & (sgn - 1)) > expall) begin
      r.bits = maxv;
      r.inv  = 1'b1;
      return r;
    end
    t   = to_integral(x, sp, 1'b0, inx);
    neg = (t & sgn) != 0;
    mag = t & (sgn - 1);
    ef  = mag >> mb;
    if (mag == 0) begin
      r.inx = inx;
    end else if (ef >= bias + w - 1) begin
      if (neg && ef == bias + w - 1 && (mag & fmask) == 0) begin
        r.bits = minv;
        r.inx  = inx;
      end else begin
        r.bits = neg ? minv : maxv;
        r.inv  = 1'b1;
      end
    end else begin
      e      = ef - bias;
      sig    = (mag & fmask) | (64'd1 << mb);
      m      = (e >= mb) ? (sig << (e - mb)) : (sig >> (mb - e));
      r.bits = neg ? -m : m;
      r.inx  = inx;
    end
    return r;
  endfunction

  // random idle burst before a beat
  task automatic idle_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // send one beat and queue its prediction
  task automatic send_op(op_e op, logic sp, logic [63:0] x);
    idle_gap();
    start              <= 1'b1;
    opcode_i           <= op;
    single_precision_i <= sp;
    operand_bits_i     <= x;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    rounded_q.push_back(round_op(op, sp, x));
    n_beats++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (rounded_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_long_width(logic val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 3'(RegLongIsWide) << 2;
    pwdata  <= {31'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    wide_long = val;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] dbl(logic s, int unsigned ex, logic [51:0] f);
    return {s, 11'(ex), f};
  endfunction

  function automatic logic [63:0] sgl(logic s, int unsigned ex, logic [22:0] f);
    return {$urandom(), s, 8'(ex), f};
  endfunction

  // operand biased toward exponents near the rounding boundaries, all-ones exponents and zero or half fractions
  function automatic logic [63:0] rand_operand(logic sp);
    logic [63:0] x;
    int unsigned k;
    x = {$urandom(), $urandom()};
    k = $urandom_range(0, 9);
    if (sp) begin
      if (k < 7) x[30:23] = 8'($urandom_range(120, 160));
      else if (k == 7) x[30:23] = 8'hFF;
      else if (k == 8) x[22:0] = $urandom_range(0, 1) ? '0 : 23'h400000;
    end else begin
      if (k < 7) x[62:52] = 11'($urandom_range(1016, 1090));
      else if (k == 7) x[62:52] = 11'h7FF;
      else if (k == 8) x[51:0] = $urandom_range(0, 1) ? '0 : 52'h8_0000_0000_0000;
    end
    return x;
  endfunction

  // zeros, halves, boundaries, NaN and infinity for all opcodes
  task automatic test_directed();
    logic [63:0] d[$];
    logic [63:0] s[$];
    d = '{dbl(0, 0, 0), dbl(1, 0, 0), dbl(0, 1022, 0), dbl(1, 1022, 0), dbl(0, 1023, 52'h8_0000_0000_0000),
          dbl(0, 1075, 1), dbl(0, 1086, 0), dbl(1, 1086, 0), dbl(0, 1085, '1), dbl(1, 1054, 0),
          dbl(0, 1054, 0), dbl(0, 2047, 0), dbl(1, 2047, 5), 64'hFFFF_FFFF_FFFF_FFFF};
    s = '{sgl(1, 0, 0), sgl(0, 126, 0), sgl(1, 150, 1), sgl(1, 158, 0), sgl(0, 190, 0),
          sgl(1, 190, 0), sgl(0, 255, 23'h7FFFFF), sgl(0, 127, 23'h3FFFFF)};
    foreach (d[i]) for (int op = 0; op < 4; op++) send_op(op_e'(op), 1'b0, d[i]);
    foreach (s[i]) for (int op = 0; op < 4; op++) send_op(op_e'(op), 1'b1, s[i]);
    drain();
  endtask

  task automatic test_random(int unsigned count);
    logic sp;
    for (int unsigned i = 0; i < count; i++) begin
      sp = $urandom_range(0, 1);
      send_op(op_e'($urandom_range(0, 3)), sp, rand_operand(sp));
    end
    drain();
  endtask

  // result check
  always @(posedge clk_i) begin
    rounded_t want;
    if (rst_ni && done_o) begin
      n_results++;
      if (rounded_q.size() == 0) begin
        $display("%0t: result with nothing expected: %h", $time, result_bits_o);
        n_err++;
      end else begin
        want = rounded_q.pop_front();
        if (want.bits !== result_bits_o) begin
          $display("%0t: result_bits exp %h got %h", $time, want.bits, result_bits_o);
          n_err++;
        end
        if (want.inv !== invalid_flag_o) begin
          $display("%0t: invalid_flag exp %b got %b", $time, want.inv, invalid_flag_o);
          n_err++;
        end
        if (want.inx !== inexact_flag_o) begin
          $display("%0t: inexact_flag exp %b got %b", $time, want.inx, inexact_flag_o);
          n_err++;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_long_width(1'b0);
    test_directed();
    test_random(400);
    write_long_width(1'b1);
    test_random(400);
    write_long_width(1'b0);
    gaps_on = 1'b0;
    test_random(420);
    if (rounded_q.size() != 0) begin
      $display("%0d results never arrived", rounded_q.size());
      n_err++;
    end
    $display("Covered %0d beats, %0d results, all opcodes, both formats, both long widths",
             n_beats, n_results);
    if (n_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
hdl/frti_pkg.sv
hdl/frti_round.sv
hdl/frti_convert.sv
hdl/fp_round_to_integral_unit.sv
sim/tb_top.sv
